// ----- rtl/core/rtp_pkg.sv -----
// Types, character constants and the digit decoder shared by the radix parser.
package rtp_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LZ    = 8'h7A;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UZ    = 8'h5A;

  localparam logic [5:0] RADIX_LOW   = 6'd2;
  localparam logic [5:0] RADIX_HIGH  = 6'd36;
  localparam logic [5:0] RADIX_RESET = 6'd10;

  // Digit code meaning "not a digit character".
  localparam logic [6:0] DIGIT_NONE = 7'd99;

  // Register index decoded from paddr.
  localparam logic REG_RADIX = 1'b0;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Product width: 64-bit accumulator times a 6-bit radix, plus sign.
  localparam int unsigned PROD_W = 71;

  typedef enum logic [1:0] {
    KIND_SIGN,
    KIND_DIGIT,
    KIND_BAD
  } rtp_kind_e;

  typedef struct packed {
    rtp_kind_e  kind;
    logic [5:0] digit;
    logic [5:0] radix;
    logic       neg;
    logic       last;
  } rtp_item_t;

  function automatic logic [6:0] digit_of(input logic [7:0] c);
    logic [6:0] d;
    d = DIGIT_NONE;
    if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
      d = 7'(c - CHAR_ZERO);
    end else if (c inside {[CHAR_LA:CHAR_LZ]}) begin
      d = 7'(c - CHAR_LA) + 7'd10;
    end else if (c inside {[CHAR_UA:CHAR_UZ]}) begin
      d = 7'(c - CHAR_UA) + 7'd10;
    end
    return d;
  endfunction

endpackage

// ----- rtl/core/rtp_front.sv -----
// Front end: accepts characters, tracks text start and sign, classifies each item.
module rtp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          char_code_i,
  input  logic                last_i,
  input  logic [5:0]          radix_i,
  input  logic                q_full_i,
  output logic                push_o,
  output rtp_pkg::rtp_item_t  item_o
);

  logic       at_start_q, at_start_d;
  logic       neg_q, neg_d;
  logic [6:0] dig;
  logic       is_sign;
  logic       radix_bad;
  logic       accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept;

  assign dig       = rtp_pkg::digit_of(char_code_i);
  assign is_sign   = (char_code_i == rtp_pkg::CHAR_PLUS) || (char_code_i == rtp_pkg::CHAR_MINUS);
  assign radix_bad = (radix_i < rtp_pkg::RADIX_LOW) || (radix_i > rtp_pkg::RADIX_HIGH);

  always_comb begin
    item_o.digit = dig[5:0];
    item_o.radix = radix_i;
    item_o.last  = last_i;
    item_o.neg   = neg_q;
    if (at_start_q && is_sign) begin
      item_o.neg  = (char_code_i == rtp_pkg::CHAR_MINUS);
      item_o.kind = last_i ? rtp_pkg::KIND_BAD : rtp_pkg::KIND_SIGN;
    end else if (radix_bad || (dig >= {1'b0, radix_i})) begin
      item_o.kind = rtp_pkg::KIND_BAD;
    end else begin
      item_o.kind = rtp_pkg::KIND_DIGIT;
    end
  end

  always_comb begin
    at_start_d = at_start_q;
    neg_d      = neg_q;
    if (accept) begin
      if (last_i) begin
        at_start_d = 1'b1;
        neg_d      = 1'b0;
      end else begin
        at_start_d = 1'b0;
        neg_d      = item_o.neg;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q <= 1'b1;
      neg_q      <= 1'b0;
    end else begin
      at_start_q <= at_start_d;
      neg_q      <= neg_d;
    end
  end

endmodule

// ----- rtl/core/rtp_fifo.sv -----
// Short item queue between the front end and the accumulator.
module rtp_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rtp_pkg::rtp_item_t  item_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output rtp_pkg::rtp_item_t  item_o
);

  rtp_pkg::rtp_item_t                   mem_q [rtp_pkg::QUEUE_DEPTH];
  logic [rtp_pkg::QPTR_W-1:0]           wr_ptr_q, wr_ptr_d;
  logic [rtp_pkg::QPTR_W-1:0]           rd_ptr_q, rd_ptr_d;
  logic [rtp_pkg::QCNT_W-1:0]           count_q, count_d;

  localparam logic [rtp_pkg::QPTR_W-1:0] PtrLast = rtp_pkg::QPTR_W'(rtp_pkg::QUEUE_DEPTH - 1);
  localparam logic [rtp_pkg::QCNT_W-1:0] CntFull = rtp_pkg::QCNT_W'(rtp_pkg::QUEUE_DEPTH);

  assign full_o  = (count_q == CntFull);
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ----- rtl/core/rtp_back.sv -----
// Back end: negative accumulator with overflow check and the result register.
module rtp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  rtp_pkg::rtp_item_t  item_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [63:0]  value_o,
  output logic                error_o
);

  logic signed [63:0]                 acc_q, acc_d;
  logic                               failed_q, failed_d;
  logic                               out_valid_q, out_valid_d;
  logic signed [63:0]                 out_acc_q;
  logic                               out_neg_q;
  logic                               out_err_q;
  logic signed [rtp_pkg::PROD_W-1:0]  prod;
  logic signed [rtp_pkg::PROD_W-1:0]  nxt;
  logic signed [rtp_pkg::PROD_W-1:0]  limit;
  logic signed [63:0]                 acc_step;
  logic                               fail_step;
  logic                               out_free;
  logic                               load;

  localparam logic signed [rtp_pkg::PROD_W-1:0] LimitNeg = {{8{1'b1}}, 63'h0};
  localparam logic signed [rtp_pkg::PROD_W-1:0] LimitPos = {{8{1'b1}}, 63'h1};

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = q_valid_i && (!item_i.last || out_free);
  assign load     = pop_o && item_i.last;

  assign prod  = $signed({{(rtp_pkg::PROD_W - 64){acc_q[63]}}, acc_q})
               * $signed({{(rtp_pkg::PROD_W - 6){1'b0}}, item_i.radix});
  assign nxt   = prod - $signed({{(rtp_pkg::PROD_W - 6){1'b0}}, item_i.digit});
  assign limit = item_i.neg ? LimitNeg : LimitPos;

  always_comb begin
    acc_step  = acc_q;
    fail_step = failed_q;
    if (!failed_q) begin
      case (item_i.kind)
        rtp_pkg::KIND_DIGIT: begin
          if (nxt < limit) begin
            fail_step = 1'b1;
          end else begin
            acc_step = nxt[63:0];
          end
        end
        rtp_pkg::KIND_BAD: fail_step = 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    acc_d       = acc_q;
    failed_d    = failed_q;
    out_valid_d = out_valid_q;
    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (pop_o) begin
      if (item_i.last) begin
        acc_d       = '0;
        failed_d    = 1'b0;
        out_valid_d = 1'b1;
      end else begin
        acc_d    = acc_step;
        failed_d = fail_step;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_acc_q <= acc_step;
      out_neg_q <= item_i.neg;
      out_err_q <= fail_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign error_o     = out_err_q;
  assign value_o     = out_err_q ? 64'sd0 : (out_neg_q ? out_acc_q : -out_acc_q);

endmodule

// ----- rtl/core/radix_integer_text_parser_core.sv -----
// Top level of the radix integer text parser: APB radix register, front, queue, back.
//
//   channel | handshake               | payload
//   --------+-------------------------+-------------------------------
//   in      | in_valid_i, in_stall_o  | char_code_i[7:0], last_i
//   out     | out_valid_o, out_stall_i| value_o[63:0] (signed), error_o
//   cfg     | psel, penable, pwrite   | paddr[2:0], pwdata, prdata
//
// One item per cycle while the queue is not full; the last item of a text passes
// through the queue write, then the accumulate into the result register.
// Accumulate: one 64x6 multiply, subtract, compare per cycle with an item queued.
// Reset returns the radix to 10 and clears the text state; no clearing pass.
// A waiting result does not stop items; the two-entry queue stalls the input
// only once a second result is due while the first is still held.
module radix_integer_text_parser_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         char_code_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [63:0] value_o,
  output logic               error_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [5:0]          radix_q, radix_d;
  logic                reg_sel;
  logic                push;
  logic                pop;
  logic                q_full;
  logic                q_valid;
  rtp_pkg::rtp_item_t  front_item;
  rtp_pkg::rtp_item_t  head_item;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == rtp_pkg::REG_RADIX);
  assign prdata  = reg_sel ? {26'd0, radix_q} : 32'd0;

  always_comb begin
    radix_d = radix_q;
    if (psel && penable && pwrite && reg_sel) begin
      radix_d = pwdata[5:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= rtp_pkg::RADIX_RESET;
    end else begin
      radix_q <= radix_d;
    end
  end

  rtp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .last_i      (last_i),
    .radix_i     (radix_q),
    .q_full_i    (q_full),
    .push_o      (push),
    .item_o      (front_item)
  );

  rtp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  rtp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .item_i      (head_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .error_o     (error_o)
  );

endmodule

// ----- tb/rtp_parse_checker.sv -----
// Checker for the radix text parser: tracks the radix, predicts each result and compares.
`timescale 1ns / 100ps

module rtp_parse_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [7:0]         char_code_i,
  input  logic               last_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [63:0] value_i,
  input  logic               error_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [2:0]         paddr_i,
  input  logic [31:0]        pwdata_i,
  input  logic [31:0]        prdata_i,
  input  logic               pready_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o
);

  localparam logic [2:0] ADDR_RADIX  = {rtp_pkg::REG_RADIX, 2'b00};
  localparam int         MAX_REPORTS = 10;
  localparam longint     S64_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint     S64_MIN     = -S64_MAX - 64'sd1;

  typedef struct packed {
    logic signed [63:0] value;
    logic               error;
  } parse_result_t;

  parse_result_t parsed_q[$];

  logic [5:0] cur_radix;
  longint     acc;
  logic       text_negative;
  logic       text_fresh;
  logic       text_bad;

  function automatic int char_value(input logic [7:0] c);
    if (c >= rtp_pkg::CHAR_ZERO && c <= rtp_pkg::CHAR_NINE) begin
      return int'(c - rtp_pkg::CHAR_ZERO);
    end
    if (c >= rtp_pkg::CHAR_LA && c <= rtp_pkg::CHAR_LZ) begin
      return int'(c - rtp_pkg::CHAR_LA) + 10;
    end
    if (c >= rtp_pkg::CHAR_UA && c <= rtp_pkg::CHAR_UZ) begin
      return int'(c - rtp_pkg::CHAR_UA) + 10;
    end
    return 99;
  endfunction

  task automatic clear_text();
    acc           = 64'sd0;
    text_negative = 1'b0;
    text_fresh    = 1'b1;
    text_bad      = 1'b0;
  endtask

  task automatic note_failure(input string msg);
    fail_count_o++;
    if (fail_count_o <= MAX_REPORTS) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  // Advance the parse by one character; a last character queues the result.
  task automatic take_char(input logic [7:0] c, input logic is_last);
    logic          sign_only;
    longint        lim;
    longint        quot;
    longint        r;
    longint        dv;
    int            d;
    parse_result_t res;
    sign_only = 1'b0;
    if (text_fresh) begin
      text_fresh = 1'b0;
      if (c == rtp_pkg::CHAR_PLUS || c == rtp_pkg::CHAR_MINUS) begin
        text_negative = (c == rtp_pkg::CHAR_MINUS);
        sign_only     = 1'b1;
        if (is_last) text_bad = 1'b1;
      end
    end
    if (!sign_only && !text_bad) begin
      if (cur_radix < rtp_pkg::RADIX_LOW || cur_radix > rtp_pkg::RADIX_HIGH) begin
        text_bad = 1'b1;
      end else begin
        lim  = text_negative ? S64_MIN : -S64_MAX;
        r    = longint'(cur_radix);
        quot = lim / r;
        d    = char_value(c);
        if (d >= int'(cur_radix) || acc < quot) begin
          text_bad = 1'b1;
        end else begin
          dv  = longint'(d);
          acc = acc * r;
          if (acc < lim + dv) text_bad = 1'b1;
          else acc = acc - dv;
        end
      end
    end
    if (is_last) begin
      res.error = text_bad;
      res.value = text_bad ? 64'sd0 : (text_negative ? acc : -acc);
      parsed_q.push_back(res);
      clear_text();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    parse_result_t exp;
    if (!rst_ni) begin
      cur_radix = rtp_pkg::RADIX_RESET;
      parsed_q.delete();
      clear_text();
      fail_count_o = 0;
      checked_o    = 0;
      pending_o    = 0;
    end else begin
      if (psel_i && penable_i && pready_i && paddr_i == ADDR_RADIX) begin
        if (pwrite_i) begin
          cur_radix = pwdata_i[5:0];
        end else if (prdata_i[5:0] !== cur_radix) begin
          note_failure($sformatf("radix readback: expected %0d, got %0d",
                                 cur_radix, prdata_i[5:0]));
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (parsed_q.size() == 0) begin
          note_failure($sformatf("unexpected result: value %0d error %0b",
                                 value_i, error_i));
        end else begin
          exp = parsed_q.pop_front();
          checked_o++;
          if (value_i !== exp.value || error_i !== exp.error) begin
            note_failure($sformatf({"result mismatch: expected value %0d error %0b,",
                                    " got value %0d error %0b"},
                                   exp.value, exp.error, value_i, error_i));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        take_char(char_code_i, last_i);
      end
      pending_o = parsed_q.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
// Testbench top for the radix text parser: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 100ps

module testbench;

  localparam logic [2:0] ADDR_RADIX    = {rtp_pkg::REG_RADIX, 2'b00};
  localparam int         RANDOM_ITEMS  = 1500;
  localparam int         SETTLE_CYCLES = 8;
  localparam int         QUIET_LIMIT   = 3000;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         char_code_i;
  logic               last_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [63:0] value_o;
  logic               error_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int fail_count;
  int pending;
  int checked;

  logic        calm = 1'b0;
  int          items_sent = 0;
  int          texts_sent = 0;
  int          radix_writes = 0;
  int          quiet = 0;
  logic [7:0]  text_q[$];

  always #10 clk_i = ~clk_i;

  radix_integer_text_parser_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .error_o     (error_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  rtp_parse_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .char_code_i  (char_code_i),
    .last_i       (last_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .value_i      (value_o),
    .error_i      (error_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] numeral_char(input int d);
    if (d < 10) return 8'(rtp_pkg::CHAR_ZERO + d);
    if ($urandom_range(0, 1)) return 8'(rtp_pkg::CHAR_UA + d - 10);
    return 8'(rtp_pkg::CHAR_LA + d - 10);
  endfunction

  function automatic logic [7:0] any_sign();
    return $urandom_range(0, 1) ? rtp_pkg::CHAR_MINUS : rtp_pkg::CHAR_PLUS;
  endfunction

  function automatic logic [5:0] pick_radix(input int phase);
    int sel;
    case (phase)
      0: return rtp_pkg::RADIX_LOW;
      1: return rtp_pkg::RADIX_HIGH;
      2: return 6'd63;
      3: return 6'd1;
      default: begin
        sel = $urandom_range(0, 19);
        if (sel < 3) return rtp_pkg::RADIX_LOW;
        if (sel < 6) return rtp_pkg::RADIX_HIGH;
        if (sel < 8) return 6'd10;
        if (sel < 10) return 6'd16;
        if (sel == 10) return $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(37, 63));
        return 6'($urandom_range(2, 36));
      end
    endcase
  endfunction

  task automatic send_char(input logic [7:0] c, input logic is_last);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    char_code_i = c;
    last_i      = is_last;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text();
    foreach (text_q[i]) begin
      send_char(text_q[i], i == text_q.size() - 1);
    end
    texts_sent++;
  endtask

  task automatic send_str(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_text();
  endtask

  task automatic apb_access(input logic wr, input logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = ADDR_RADIX;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_radix(input logic [5:0] r);
    logic [25:0] upper;
    upper = ($urandom_range(0, 3) == 0) ? 26'($urandom) : 26'd0;
    apb_access(1'b1, {upper, r});
    apb_access(1'b0, 32'd0);
    radix_writes++;
  endtask

  // Block must be between texts with all results out before the radix changes.
  task automatic settle();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Signed number text of a random magnitude in the given base, overflows included.
  task automatic build_number(input int base);
    logic [63:0] mag;
    int          pick;
    text_q.delete();
    pick = $urandom_range(0, 9);
    case (pick)
      0: mag = 64'h7FFF_FFFF_FFFF_FFFF + 64'($urandom_range(0, 2));
      1: mag = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 40));
      2: mag = 64'h0 - 64'($urandom_range(1, 3));
      3: mag = 64'($urandom_range(0, 40));
      default: mag = {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
    do begin
      text_q.push_front(numeral_char(int'(mag % 64'(base))));
      mag = mag / 64'(base);
    end while (mag != 64'd0);
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) text_q.push_front(rtp_pkg::CHAR_ZERO);
    end
    if ($urandom_range(0, 1)) text_q.push_front(rtp_pkg::CHAR_MINUS);
    else if ($urandom_range(0, 3) == 0) text_q.push_front(rtp_pkg::CHAR_PLUS);
  endtask

  task automatic random_text(input int base);
    int kind;
    int pos;
    kind = $urandom_range(0, 19);
    if (kind < 12) begin
      build_number(base);
    end else if (kind < 17) begin
      text_q.delete();
      repeat ($urandom_range(1, 6)) begin
        text_q.push_back(($urandom_range(0, 3) == 0) ? any_sign() : 8'($urandom_range(0, 255)));
      end
    end else begin
      build_number(base);
      pos = $urandom_range(0, text_q.size() - 1);
      text_q[pos] = $urandom_range(0, 1) ? any_sign() : 8'($urandom_range(0, 255));
    end
    send_text();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (psel && penable && pready)) begin
        quiet <= 0;
      end else if (quiet + 1 >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $realtime, QUIET_LIMIT);
        $display("radix_integer_text_parser_core verification failed");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin : stall_gen
    int len;
    out_stall_i = 1'b0;
    wait (rst_ni);
    forever begin
      len = idle_len();
      if (len > 0) begin
        out_stall_i = 1'b1;
        repeat (len) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  end

  initial begin : stimulus
    int         phase;
    int         start_items;
    int         base;
    logic [5:0] r;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    char_code_i = 8'd0;
    last_i      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = 3'd0;
    pwdata      = 32'd0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: signs, bad digits, byte extremes, then high and invalid radix
    send_str("+");
    send_str("-");
    send_str("0");
    send_str("+7");
    send_str("-9");
    send_str("1-2");
    send_str("a");
    send_char(8'hFF, 1'b1);
    send_char(8'h00, 1'b1);
    send_str("+-");
    send_str("Zz");
    settle();
    set_radix(rtp_pkg::RADIX_HIGH);
    send_str("Zz");
    send_str("-10");
    settle();
    set_radix(6'd0);
    send_str("5");
    send_str("-");

    phase       = 0;
    start_items = items_sent;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      settle();
      r = pick_radix(phase);
      set_radix(r);
      base = (r >= rtp_pkg::RADIX_LOW && r <= rtp_pkg::RADIX_HIGH) ?
             int'(r) : $urandom_range(2, 36);
      calm = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(4, 12)) random_text(base);
      calm = 1'b0;
      phase++;
    end

    settle();
    $display("%0d items in %0d texts, %0d results checked over %0d radix writes",
             items_sent, texts_sent, checked, radix_writes);
    $display("radices 2 and 36 and out-of-range values, int64 extremes and overflow exercised");
    if (fail_count == 0) begin
      $display("radix_integer_text_parser_core verification clean");
    end else begin
      $display("radix_integer_text_parser_core verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/rtp_pkg.sv
rtl/core/rtp_front.sv
rtl/core/rtp_fifo.sv
rtl/core/rtp_back.sv
rtl/core/radix_integer_text_parser_core.sv
tb/rtp_parse_checker.sv
tb/testbench.sv
